// ===== rtl/level_set_reinit_rate_top_macros.svh =====
// assertion macros for the level set reinitialization rate block
`ifndef LEVEL_SET_REINIT_RATE_TOP_MACROS_SVH
`define LEVEL_SET_REINIT_RATE_TOP_MACROS_SVH

// same-cycle implication, reset masked
`define LSR_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, reset masked
`define LSR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/lsr_pkg.sv =====
// shared types and constants of the level set reinitialization rate block
`default_nettype none
package lsr_pkg;

  // fixed point format
  localparam int VW = 32;
  localparam int FB = 16;
  localparam logic [31:0] FONE = 32'd65536;
  localparam logic [30:0] VMAX31 = 31'h7fffffff;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SPACING = 2'd1;

  // square root pipeline: 32 root bits, four per stage
  localparam int SQ_STAGES = 8;
  localparam int SQ_STEPS = 4;

  // divider pipeline: 18 quotient bits, six per stage
  localparam int DIV_STAGES = 3;
  localparam int DIV_STEPS = 6;
  localparam int Q_W = DIV_STAGES * DIV_STEPS;

  // total register stages from input to output
  localparam int FRONT_STAGES = 5;
  localparam int PIPE_DEPTH = FRONT_STAGES + SQ_STAGES + DIV_STAGES + 2;

  typedef struct packed {
    logic [63:0] x;
    logic [34:0] rem;
    logic [31:0] root;
  } lsr_sq_t;

  typedef struct packed {
    logic [31:0]    rem;
    logic [Q_W-1:0] nb;
    logic [Q_W-1:0] q;
    logic [31:0]    d;
  } lsr_dv_t;

  typedef struct packed {
    logic        cneg;
    logic [31:0] av;
  } lsr_sqside_t;

  typedef struct packed {
    logic        cneg;
    logic        gneg;
    logic [31:0] gmag;
    logic        dz;
  } lsr_dvside_t;

endpackage
`default_nettype wire

// ===== rtl/level_set_reinit_rate_top.sv =====
// top level of the level set reinitialization rate pipeline
`default_nettype none
`include "level_set_reinit_rate_top_macros.svh"
// Computes the upwind reinitialization rate of one grid cell per clock from
// the cell value and its four neighbors, in signed Q16.16 with a saturated result.
// The pipeline is 18 register stages deep, and one beat is taken every cycle while
// the output is not stalled. The depth is set by the two parallel 8-stage
// square roots (gradient norm and sign denominator) and the 3-stage divider
// for the smoothed sign. An output stall while out_valid is high freezes the
// whole pipeline. Configuration writes are always ready and should be made
// while no beat is in flight.
module level_set_reinit_rate_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [31:0]             in_centre_value,
  input  wire logic signed [31:0]             in_west_value,
  input  wire logic signed [31:0]             in_east_value,
  input  wire logic signed [31:0]             in_south_value,
  input  wire logic signed [31:0]             in_north_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [31:0]                  out_rate_of_change,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  localparam int N = lsr_pkg::PIPE_DEPTH;
  localparam int DIV_OUT_IDX = lsr_pkg::FRONT_STAGES + lsr_pkg::SQ_STAGES
                               + lsr_pkg::DIV_STAGES - 1;

  logic          en;
  logic [N-1:0]  vld_r;
  logic [30:0]   h_r;
  logic [30:0]   inv_r;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r   <= 31'd65536;
      inv_r <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsr_pkg::CFG_GRID_SPACING:    h_r   <= cfg_data[30:0];
        lsr_pkg::CFG_INVERSE_SPACING: inv_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // global advance, valid bits travel with the data
  assign en        = !(vld_r[N-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
  end

  // upwind one-sided difference magnitude for one axis
  function automatic logic [31:0] upwind(logic signed [31:0] c, logic signed [31:0] a,
                                         logic signed [31:0] b, logic pos);
    logic signed [31:0] ms;
    logic signed [32:0] d;
    if (pos) ms = (a < b) ? a : b;
    else     ms = (a > b) ? a : b;
    if (pos) d = {c[31], c} - {ms[31], ms};
    else     d = {ms[31], ms} - {c[31], c};
    return (d > 33'sd0) ? d[31:0] : 32'd0;
  endfunction

  // stage 1: upwind differences and centre magnitude
  logic                 cpos;
  logic [32:0]          negc;
  logic [31:0]          diffx1_r, diffy1_r;
  lsr_pkg::lsr_sqside_t side1_r;

  assign cpos = !in_centre_value[31] && (|in_centre_value);
  assign negc = 33'd0 - {in_centre_value[31], in_centre_value};

  always_ff @(posedge clk) begin
    if (en) begin
      diffx1_r     <= upwind(in_centre_value, in_west_value, in_east_value, cpos);
      diffy1_r     <= upwind(in_centre_value, in_south_value, in_north_value, cpos);
      side1_r.cneg <= in_centre_value[31];
      side1_r.av   <= in_centre_value[31] ? negc[31:0] : in_centre_value;
    end
  end

  // stage 2: scale by inverse spacing, square the centre
  logic [62:0]          mx2_r, my2_r;
  logic [63:0]          avsq2_r;
  lsr_pkg::lsr_sqside_t side2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mx2_r   <= {31'd0, diffx1_r} * {32'd0, inv_r};
      my2_r   <= {31'd0, diffy1_r} * {32'd0, inv_r};
      avsq2_r <= {32'd0, side1_r.av} * {32'd0, side1_r.av};
      side2_r <= side1_r;
    end
  end

  // stage 3: drop fraction and saturate, form sign radicand
  logic [30:0]          dx3_r, dy3_r;
  logic [63:0]          rads3_r;
  lsr_pkg::lsr_sqside_t side3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx3_r   <= (|mx2_r[62:47]) ? lsr_pkg::VMAX31 : mx2_r[46:16];
      dy3_r   <= (|my2_r[62:47]) ? lsr_pkg::VMAX31 : my2_r[46:16];
      rads3_r <= avsq2_r + {17'd0, h_r, 16'd0};
      side3_r <= side2_r;
    end
  end

  // stage 4: square the derivatives
  logic [61:0]          dxx4_r, dyy4_r;
  logic [63:0]          rads4_r;
  lsr_pkg::lsr_sqside_t side4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dxx4_r  <= {31'd0, dx3_r} * {31'd0, dx3_r};
      dyy4_r  <= {31'd0, dy3_r} * {31'd0, dy3_r};
      rads4_r <= rads3_r;
      side4_r <= side3_r;
    end
  end

  // stage 5: gradient radicand
  logic [62:0]          gsum;
  logic [63:0]          radn5_r, rads5_r;
  lsr_pkg::lsr_sqside_t side5_r;

  assign gsum = {1'b0, dxx4_r} + {1'b0, dyy4_r};

  always_ff @(posedge clk) begin
    if (en) begin
      radn5_r <= {1'b0, gsum};
      rads5_r <= rads4_r;
      side5_r <= side4_r;
    end
  end

  // square roots, side data delayed alongside
  logic [31:0]          norm, den;
  lsr_pkg::lsr_sqside_t sq_side_r [lsr_pkg::SQ_STAGES];

  lsr_sqrt_pipe u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_a  (radn5_r),
    .rad_b  (rads5_r),
    .root_a (norm),
    .root_b (den)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0] <= side5_r;
      for (int k = 1; k < lsr_pkg::SQ_STAGES; k++) begin
        sq_side_r[k] <= sq_side_r[k-1];
      end
    end
  end

  // distance of the norm from one, then the sign quotient
  logic                 gneg;
  logic [31:0]          gmag;
  logic [lsr_pkg::Q_W-1:0] div_q;
  lsr_pkg::lsr_dvside_t dv_side_r [lsr_pkg::DIV_STAGES];

  assign gneg = norm > lsr_pkg::FONE;
  assign gmag = gneg ? (norm - lsr_pkg::FONE) : (lsr_pkg::FONE - norm);

  lsr_div_pipe u_div (
    .clk (clk),
    .en  (en),
    .av  (sq_side_r[lsr_pkg::SQ_STAGES-1].av),
    .den (den),
    .quo (div_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0].cneg <= sq_side_r[lsr_pkg::SQ_STAGES-1].cneg;
      dv_side_r[0].gneg <= gneg;
      dv_side_r[0].gmag <= gmag;
      dv_side_r[0].dz   <= (den == 32'd0);
      for (int k = 1; k < lsr_pkg::DIV_STAGES; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  // sign magnitude times gradient term
  lsr_pkg::lsr_dvside_t dvo;
  logic [lsr_pkg::Q_W-1:0] smag;
  logic [49:0]          prod_r;
  logic                 rneg_r;

  assign dvo  = dv_side_r[lsr_pkg::DIV_STAGES-1];
  assign smag = dvo.dz ? '0 : div_q;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {32'd0, smag} * {18'd0, dvo.gmag};
      rneg_r <= dvo.cneg ^ dvo.gneg;
    end
  end

  // saturate and apply the sign
  logic [33:0] pr, lim, mag;
  logic [31:0] negm;
  logic [31:0] rate_r;

  assign pr   = prod_r[49:16];
  assign lim  = rneg_r ? 34'h080000000 : 34'h07fffffff;
  assign mag  = (pr > lim) ? lim : pr;
  assign negm = 32'd0 - mag[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      rate_r <= rneg_r ? negm : mag[31:0];
    end
  end

  assign out_rate_of_change = rate_r;

  // checks
  `LSR_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld_r[0], "accepted beat lost")
  `LSR_ASSERT_NEXT(a_freeze_holds, !en, $stable(vld_r), "pipeline moved while frozen")
  `LSR_ASSERT_SAME(a_sign_bound, vld_r[DIV_OUT_IDX] && !dvo.dz, div_q <= 18'd65536, "sign over one")

endmodule
`default_nettype wire

// ===== rtl/lsr_sqrt_pipe.sv =====
// two-lane pipelined floor square root of 64-bit radicands
`default_nettype none
module lsr_sqrt_pipe (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] rad_a,
  input  wire logic [63:0] rad_b,
  output logic      [31:0] root_a,
  output logic      [31:0] root_b
);

  lsr_pkg::lsr_sq_t st_a_r [lsr_pkg::SQ_STAGES];
  lsr_pkg::lsr_sq_t st_b_r [lsr_pkg::SQ_STAGES];

  // digit-by-digit root, two radicand bits per step
  function automatic lsr_pkg::lsr_sq_t sq_steps(lsr_pkg::lsr_sq_t s);
    lsr_pkg::lsr_sq_t t;
    logic [34:0] rn;
    logic [34:0] tr;
    t = s;
    for (int i = 0; i < lsr_pkg::SQ_STEPS; i++) begin
      rn = {t.rem[32:0], t.x[63:62]};
      tr = {1'b0, t.root, 2'b01};
      if (rn >= tr) begin
        t.rem  = rn - tr;
        t.root = {t.root[30:0], 1'b1};
      end else begin
        t.rem  = rn;
        t.root = {t.root[30:0], 1'b0};
      end
      t.x = {t.x[61:0], 2'b00};
    end
    return t;
  endfunction

  function automatic lsr_pkg::lsr_sq_t sq_init(logic [63:0] rad);
    lsr_pkg::lsr_sq_t t;
    t.x    = rad;
    t.rem  = '0;
    t.root = '0;
    return t;
  endfunction

  // stage registers advance together
  always_ff @(posedge clk) begin
    if (en) begin
      st_a_r[0] <= sq_steps(sq_init(rad_a));
      st_b_r[0] <= sq_steps(sq_init(rad_b));
      for (int k = 1; k < lsr_pkg::SQ_STAGES; k++) begin
        st_a_r[k] <= sq_steps(st_a_r[k-1]);
        st_b_r[k] <= sq_steps(st_b_r[k-1]);
      end
    end
  end

  assign root_a = st_a_r[lsr_pkg::SQ_STAGES-1].root;
  assign root_b = st_b_r[lsr_pkg::SQ_STAGES-1].root;

endmodule
`default_nettype wire

// ===== rtl/lsr_div_pipe.sv =====
// pipelined restoring divider for the smoothed sign quotient
`default_nettype none
module lsr_div_pipe (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [31:0]             av,
  input  wire logic [31:0]             den,
  output logic      [lsr_pkg::Q_W-1:0] quo
);

  lsr_pkg::lsr_dv_t st_r [lsr_pkg::DIV_STAGES];

  // one quotient bit per step
  function automatic lsr_pkg::lsr_dv_t dv_steps(lsr_pkg::lsr_dv_t s);
    lsr_pkg::lsr_dv_t t;
    logic [32:0] rn;
    logic [32:0] df;
    t = s;
    for (int i = 0; i < lsr_pkg::DIV_STEPS; i++) begin
      rn = {t.rem, t.nb[lsr_pkg::Q_W-1]};
      df = rn - {1'b0, t.d};
      if (rn >= {1'b0, t.d}) begin
        t.rem = df[31:0];
        t.q   = {t.q[lsr_pkg::Q_W-2:0], 1'b1};
      end else begin
        t.rem = rn[31:0];
        t.q   = {t.q[lsr_pkg::Q_W-2:0], 1'b0};
      end
      t.nb = {t.nb[lsr_pkg::Q_W-2:0], 1'b0};
    end
    return t;
  endfunction

  // numerator is av shifted up by the fraction bits
  function automatic lsr_pkg::lsr_dv_t dv_init(logic [31:0] a, logic [31:0] d);
    lsr_pkg::lsr_dv_t t;
    t.rem = {2'b00, a[31:2]};
    t.nb  = {a[1:0], {lsr_pkg::FB{1'b0}}};
    t.q   = '0;
    t.d   = d;
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= dv_steps(dv_init(av, den));
      for (int k = 1; k < lsr_pkg::DIV_STAGES; k++) begin
        st_r[k] <= dv_steps(st_r[k-1]);
      end
    end
  end

  assign quo = st_r[lsr_pkg::DIV_STAGES-1].q;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// testbench for the level set reinitialization rate pipeline
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_centre_value = '0;
  logic signed [31:0] in_west_value = '0;
  logic signed [31:0] in_east_value = '0;
  logic signed [31:0] in_south_value = '0;
  logic signed [31:0] in_north_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_rate_of_change;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lsr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor copy of the spacing registers
  logic [30:0] spacing_h = 31'd65536;
  logic [30:0] spacing_inv = 31'd65536;

  logic [31:0] rate_q[$];
  int errors = 0;
  bit calm = 1'b0;

  level_set_reinit_rate_top u_dut (.*);

  always #1 clk = ~clk;

  // floored square root of a wide value
  function automatic logic [63:0] floor_sqrt(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] cand;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= x) r = cand;
    end
    return r;
  endfunction

  // scaled upwind derivative magnitude along one axis
  function automatic logic [63:0] upwind_slope(longint c, longint a, longint b, bit pos);
    longint m;
    logic [63:0] diff;
    logic [127:0] p;
    diff = '0;
    if (pos) begin
      m = (a < b) ? a : b;
      if (c > m) diff = c - m;
    end else begin
      m = (a > b) ? a : b;
      if (m > c) diff = m - c;
    end
    p = ({64'd0, diff} * {97'd0, spacing_inv}) >> lsr_pkg::FB;
    return (p > 128'h7fffffff) ? 64'h7fffffff : p[63:0];
  endfunction

  // expected reinitialization rate of one cell
  function automatic logic [31:0] predict_rate(logic signed [31:0] c, w, e, s, n);
    bit cneg, cpos, gneg, rneg;
    logic [63:0] dx, dy, norm, gmag, av, den, smag, lim, mag;
    logic [127:0] prod;
    cneg = c < 0;
    cpos = c > 0;
    dx = upwind_slope(c, w, e, cpos);
    dy = upwind_slope(c, s, n, cpos);
    norm = floor_sqrt({64'd0, dx} * dx + {64'd0, dy} * dy);
    gneg = norm > 64'd65536;
    gmag = gneg ? norm - 64'd65536 : 64'd65536 - norm;
    av = cneg ? -longint'(c) : longint'(c);
    den = floor_sqrt({64'd0, av} * av + {97'd0, spacing_h} * 128'd65536);
    smag = (den == 0) ? '0 : 64'(({64'd0, av} << lsr_pkg::FB) / den);
    prod = ({64'd0, smag} * gmag) >> lsr_pkg::FB;
    rneg = cneg != gneg;
    lim = rneg ? 64'h80000000 : 64'h7fffffff;
    mag = (prod > {64'd0, lim}) ? lim : prod[63:0];
    return rneg ? 32'(-mag) : mag[31:0];
  endfunction

  // result side: random stall before each beat, none in the calm phase
  initial begin
    int k;
    @(posedge rst_n);
    forever begin
      k = calm ? 0 : $urandom_range(0, 16);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    logic [31:0] exp_rate;
    if (rst_n && out_valid && !out_stall) begin
      if (rate_q.size() == 0) begin
        $error("unexpected result beat rate_of_change=%h", out_rate_of_change);
        errors++;
      end else begin
        exp_rate = rate_q.pop_front();
        if (out_rate_of_change !== exp_rate) begin
          $error("rate_of_change expected %h actual %h", exp_rate, out_rate_of_change);
          errors++;
        end
      end
    end
  end

  task automatic send_cell(logic signed [31:0] c, w, e, s, n);
    int k;
    k = calm ? 0 : $urandom_range(0, 16);
    if (k > 0) begin
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_centre_value <= c;
    in_west_value <= w;
    in_east_value <= e;
    in_south_value <= s;
    in_north_value <= n;
    do @(posedge clk); while (in_stall);
    rate_q.push_back(predict_rate(c, w, e, s, n));
  endtask

  // stop sending and wait for every result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rate_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write, channel left idle afterwards
  task automatic write_reg(logic [lsr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lsr_pkg::CFG_GRID_SPACING) spacing_h = data[30:0];
    else if (idx == lsr_pkg::CFG_INVERSE_SPACING) spacing_inv = data[30:0];
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand32();
    return $urandom();
  endfunction

  // one cell near a smooth surface: neighbors close to the centre
  task automatic send_smooth_cell();
    logic signed [31:0] c;
    int span;
    span = 1 << $urandom_range(4, 20);
    c = $signed($urandom_range(0, 2 * 524288)) - 524288;
    send_cell(c, c + $signed($urandom_range(0, 2 * span)) - span,
              c + $signed($urandom_range(0, 2 * span)) - span,
              c + $signed($urandom_range(0, 2 * span)) - span,
              c + $signed($urandom_range(0, 2 * span)) - span);
  endtask

  // directed extremes and special cells
  task automatic test_directed();
    logic signed [31:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send_cell(0, 0, 0, 0, 0);
    send_cell(0, mx, mn, mx, mn);
    send_cell(mx, mn, mn, mn, mn);
    send_cell(mn, mx, mx, mx, mx);
    send_cell(mx, mx, mx, mx, mx);
    send_cell(mn, mn, mn, mn, mn);
    send_cell(1, 0, 0, 0, 0);
    send_cell(-1, 0, 0, 0, 0);
    send_cell(32'h10000, 0, 32'h20000, 0, 32'h20000);
    send_cell(-32'sh10000, 0, -32'sh20000, 0, -32'sh20000);
    send_cell(32'h8000, 32'h8000, 32'h8000, 32'h8000, 32'h8000);
    send_cell(mx, 0, 0, mx, mx);
    send_cell(mn, 0, 0, mn, mn);
    send_cell(32'h10000, 32'h10000 - 32'hb505, 32'h10000, 32'h10000 - 32'hb505, 32'h10000);
    drain();
    // zero spacing with a zero centre, and zero inverse spacing
    write_reg(lsr_pkg::CFG_GRID_SPACING, 32'd0);
    write_reg(lsr_pkg::CFG_INVERSE_SPACING, 32'd0);
    send_cell(0, mx, mn, 5, -5);
    send_cell(32'h30000, 0, 0, 0, 0);
    send_cell(mn, mx, mx, mx, mx);
    send_cell(-7, 3, 3, 3, 3);
    drain();
    write_reg(lsr_pkg::CFG_GRID_SPACING, 32'hffffffff);
    write_reg(lsr_pkg::CFG_INVERSE_SPACING, 32'hffffffff);
    send_cell(1, mn, mn, mn, mn);
    send_cell(mx, mn, mn, 0, 0);
    send_cell(-1, mx, mx, mx, mx);
    send_cell(32'h10000, 32'hffff, 32'h10000, 32'h10000, 32'h10000);
    drain();
  endtask

  // random cells over a list of spacing settings, then over random settings
  task automatic test_random();
    logic [31:0] h_set[6] = '{32'h10000, 32'h1, 32'h7fffffff, 32'h4000, 32'h0, 32'h80001000};
    logic [31:0] inv_set[6] = '{32'h10000, 32'h7fffffff, 32'h1, 32'h40000, 32'h0, 32'h800000ff};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) begin
        write_reg(lsr_pkg::CFG_GRID_SPACING, h_set[ph]);
        write_reg(lsr_pkg::CFG_INVERSE_SPACING, inv_set[ph]);
      end else begin
        write_reg(lsr_pkg::CFG_GRID_SPACING, rand32());
        write_reg(lsr_pkg::CFG_INVERSE_SPACING, $urandom_range(1, 1 << 20));
      end
      calm = (ph == 2);
      for (int i = 0; i < 170; i++) begin
        if ($urandom_range(0, 3) != 0) send_smooth_cell();
        else send_cell(rand32(), rand32(), rand32(), rand32(), rand32());
        // hold off until the pipeline has emptied once mid phase
        if (ph == 3 && i == 80) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (rate_q.size() != 0) @(posedge clk);
        end
      end
      calm = 1'b0;
      drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    repeat (30) @(posedge clk);
    if (errors == 0 && rate_q.size() == 0) begin
      $display("** level_set_reinit_rate_top: PASSED **");
    end else begin
      $display("** level_set_reinit_rate_top: FAILED **");
    end
    $finish;
  end

  // run time limit
  initial begin
    #2000000;
    $display("** level_set_reinit_rate_top: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
